// ----- rtl/indirect_matrix_block_float_encoder_macros.svh -----
// Assertion macros for the indirect matrix block-float encoder.
// No dependencies; included by the top level.
`ifndef INDIRECT_MATRIX_BLOCK_FLOAT_ENCODER_MACROS_SVH
`define INDIRECT_MATRIX_BLOCK_FLOAT_ENCODER_MACROS_SVH
`ifndef SYNTHESIS
`define IMBFE_ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("imbfe assertion failed");
`define IMBFE_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("imbfe assertion failed");
`else
`define IMBFE_ASSERT_IMPLY(label, clk, rst, a, b)
`define IMBFE_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ----- rtl/imbfe_pkg.sv -----
// Shared types and constants of the indirect matrix block-float encoder.
// No dependencies.
package imbfe_pkg;
   localparam int NUM_LANES = 6;
   localparam logic [5:0] BIASED_MAX = 6'd63;   // scale 46 plus bias 17
   localparam logic [10:0] CODE_POS_SAT = 11'h3FF;
   localparam logic [10:0] CODE_NEG_SAT = 11'h400;
   localparam logic [7:0] ID_OFS_A = 8'd6;
   localparam logic [7:0] ID_OFS_B = 8'd7;
   localparam logic [7:0] ID_OFS_C = 8'd8;
   localparam logic signed [8:0] MSB_NONE = -9'sd256;

   // per-element result of the exponent scan
   typedef struct packed {
      logic              special;   // all-ones exponent
      logic              zero;
      logic signed [8:0] msb;       // floor(log2 |x|) for finite nonzero x
   } scan_type;
endpackage

// ----- rtl/imbfe_req_if.sv -----
// Request channel: six binary32 elements and the matrix slot.
// No dependencies.
interface imbfe_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] row0_col0;
   logic [31:0] row0_col1;
   logic [31:0] row0_col2;
   logic [31:0] row1_col0;
   logic [31:0] row1_col1;
   logic [31:0] row1_col2;
   logic [7:0]  matrix_slot;
   modport source (output valid, row0_col0, row0_col1, row0_col2, row1_col0,
                   row1_col1, row1_col2, matrix_slot, input ready);
   modport sink (input valid, row0_col0, row0_col1, row0_col2, row1_col0,
                 row1_col1, row1_col2, matrix_slot, output ready);
endinterface

// ----- rtl/imbfe_rsp_if.sv -----
// Response channel: three register words and the biased scale.
// No dependencies.
interface imbfe_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] word_a;
   logic [31:0] word_b;
   logic [31:0] word_c;
   logic [5:0]  biased_scale;
   modport source (output valid, word_a, word_b, word_c, biased_scale, input ready);
   modport sink (input valid, word_a, word_b, word_c, biased_scale, output ready);
endinterface

// ----- rtl/indirect_matrix_block_float_encoder.sv -----
// Indirect matrix block-float encoder. Each item carries six binary32
// elements and a slot; the block picks one shared power-of-two scale so the
// largest magnitude lands in [0.5,1), clamped to -17..46 (46 whenever an
// infinity or NaN is present), and packs six saturated 11-bit codes into
// three register words with ids slot+6..slot+8. The stages are scan lanes,
// scale merge, and quantize lanes into the output register; one
// item is taken every cycle and each stage holds only while its successor
// is full and stalled. Depends on imbfe_pkg, the two channel interfaces,
// the lane modules and the assertion macro header.
`include "indirect_matrix_block_float_encoder_macros.svh"
module indirect_matrix_block_float_encoder import imbfe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   imbfe_req_if.sink   req_ch,
   imbfe_rsp_if.source rsp_ch
);
   logic [31:0] elem_in [NUM_LANES];
   scan_type    scan_in [NUM_LANES];

   // stage 1: elements and scan results
   logic        v1_ff;
   logic [31:0] e1_ff [NUM_LANES];
   logic [7:0]  slot1_ff;
   scan_type    scan1_ff [NUM_LANES];
   // stage 2: elements and shared scale
   logic        v2_ff;
   logic [31:0] e2_ff [NUM_LANES];
   logic [7:0]  slot2_ff;
   logic [5:0]  bs2_ff;
   logic [5:0]  bs2_in;
   // stage 3: output register
   logic        v3_ff;
   logic [31:0] wa_ff, wb_ff, wc_ff;
   logic [5:0]  bs3_ff;
   logic [10:0] code [NUM_LANES];

   logic rdy1, rdy2, rdy3;

   assign rdy3 = !v3_ff || rsp_ch.ready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_ch.ready = rdy1;

   assign elem_in[0] = req_ch.row0_col0;
   assign elem_in[1] = req_ch.row0_col1;
   assign elem_in[2] = req_ch.row0_col2;
   assign elem_in[3] = req_ch.row1_col0;
   assign elem_in[4] = req_ch.row1_col1;
   assign elem_in[5] = req_ch.row1_col2;

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      imbfe_scan_lane u_scan (.elem(elem_in[g]), .scan(scan_in[g]));
      imbfe_quant_lane u_quant (.elem(e2_ff[g]), .biased_scale(bs2_ff),
                                .code(code[g]));
   end

   imbfe_merge u_merge (.scans(scan1_ff), .biased_scale(bs2_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_ch.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         e1_ff    <= elem_in;
         scan1_ff <= scan_in;
         slot1_ff <= req_ch.matrix_slot;
      end
      if (rdy2) begin
         e2_ff    <= e1_ff;
         slot2_ff <= slot1_ff;
         bs2_ff   <= bs2_in;
      end
      if (rdy3) begin
         // word: id, two scale bits, row 1 code, row 0 code
         wa_ff  <= {slot2_ff + ID_OFS_A, bs2_ff[1:0], code[3], code[0]};
         wb_ff  <= {slot2_ff + ID_OFS_B, bs2_ff[3:2], code[4], code[1]};
         wc_ff  <= {slot2_ff + ID_OFS_C, bs2_ff[5:4], code[5], code[2]};
         bs3_ff <= bs2_ff;
      end
   end

   assign rsp_ch.valid        = v3_ff;
   assign rsp_ch.word_a       = wa_ff;
   assign rsp_ch.word_b       = wb_ff;
   assign rsp_ch.word_c       = wc_ff;
   assign rsp_ch.biased_scale = bs3_ff;

   `IMBFE_ASSERT_NEXT(a_accept_fills, clock, reset, req_ch.valid && req_ch.ready, v1_ff)
   `IMBFE_ASSERT_IMPLY(a_scale_bits, clock, reset, rsp_ch.valid, (rsp_ch.word_a[23:22] == rsp_ch.biased_scale[1:0]) && (rsp_ch.word_c[23:22] == rsp_ch.biased_scale[5:4]))
   `IMBFE_ASSERT_IMPLY(a_ids_step, clock, reset, rsp_ch.valid, rsp_ch.word_b[31:24] == rsp_ch.word_a[31:24] + 8'd1)
   `IMBFE_ASSERT_NEXT(a_special_max, clock, reset, v1_ff && rdy2 && scan1_ff[0].special, bs2_ff == BIASED_MAX)
endmodule

// ----- rtl/imbfe_scan_lane.sv -----
// Exponent scan of one binary32 element.
// Depends on imbfe_pkg.
module imbfe_scan_lane import imbfe_pkg::*; (
   input  logic [31:0] elem,
   output scan_type    scan
);
   logic [7:0]  exp_bits;
   logic [22:0] mant;
   logic [4:0]  top_bit;

   assign exp_bits = elem[30:23];
   assign mant     = elem[22:0];

   always_comb begin
      top_bit = 5'd0;
      for (int i = 0; i < 23; i++) begin
         if (mant[i]) top_bit = 5'(i);
      end
   end

   always_comb begin
      scan.special = (exp_bits == 8'hFF);
      scan.zero    = (exp_bits == 8'h00) && (mant == 23'd0);
      if (exp_bits != 8'h00) begin
         scan.msb = $signed({1'b0, exp_bits}) - 9'sd127;
      end else begin
         // subnormal: weight of the leading one
         scan.msb = $signed({4'b0, top_bit}) - 9'sd149;
      end
   end
endmodule

// ----- rtl/imbfe_merge.sv -----
// Merges the lane scans into one shared biased scale.
// Depends on imbfe_pkg.
module imbfe_merge import imbfe_pkg::*; (
   input  scan_type   scans [NUM_LANES],
   output logic [5:0] biased_scale
);
   logic signed [8:0] top;
   logic              any_special;
   logic signed [9:0] want;

   always_comb begin
      top         = MSB_NONE;
      any_special = 1'b0;
      for (int i = 0; i < NUM_LANES; i++) begin
         if (scans[i].special) any_special = 1'b1;
         if (!scans[i].zero && (scans[i].msb > top)) top = scans[i].msb;
      end
      // scale = msb + 1, biased by 17
      want = 10'(top) + 10'sd18;
      if (any_special || want > 10'sd63) begin
         biased_scale = BIASED_MAX;
      end else if (want < 10'sd0) begin
         biased_scale = 6'd0;
      end else begin
         biased_scale = want[5:0];
      end
   end
endmodule

// ----- rtl/imbfe_quant_lane.sv -----
// Scales one element by the shared scale and truncates to an 11-bit code.
// Depends on imbfe_pkg.
module imbfe_quant_lane import imbfe_pkg::*; (
   input  logic [31:0] elem,
   input  logic [5:0]  biased_scale,
   output logic [10:0] code
);
   logic [7:0]        exp_bits;
   logic [23:0]       sig;
   logic signed [9:0] k;
   logic [9:0]        r;
   logic [34:0]       mag;
   logic              big;
   logic              is_nan;

   assign exp_bits = elem[30:23];
   assign sig      = {exp_bits != 8'h00, elem[22:0]};
   assign is_nan   = (exp_bits == 8'hFF) && (elem[22:0] != 23'd0);
   // shift = exp - 142 - scale, with subnormals at exponent 1
   assign k = $signed({2'b0, (exp_bits == 8'h00) ? 8'd1 : exp_bits})
              - 10'sd125 - $signed({4'b0, biased_scale});
   assign r = 10'(-k);

   always_comb begin
      big = 1'b0;
      mag = '0;
      if (k >= 10'sd11) begin
         big = (sig != 24'd0);
      end else if (k >= 10'sd0) begin
         mag = {11'b0, sig} << k[3:0];
      end else if (r < 10'd24) begin
         mag = {11'b0, sig >> r[4:0]};
      end
   end

   always_comb begin
      if (is_nan) begin
         code = 11'd0;
      end else if (!elem[31]) begin
         code = (big || mag >= 35'd1023) ? CODE_POS_SAT : mag[10:0];
      end else begin
         code = (big || mag >= 35'd1024) ? CODE_NEG_SAT : 11'(-mag[10:0]);
      end
   end
endmodule
